// File: rtl/core/sdsvf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsvf_pkg
// Shared types and constants of the stereo band filter.
// ----------------------------------------------------------------------------
package sdsvf_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int STATE_WIDTH_DEF  = 32;
    localparam int COEF_WIDTH       = 32;
    localparam int WEIGHT_WIDTH     = 16;
    localparam int GAIN_WIDTH       = 18;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam logic [GAIN_WIDTH-1:0] GAIN_MAX = 18'd131072;
    localparam longint T_Q30 = 966367642;
    localparam longint D_Q30 = 107374182;

    typedef enum logic [2:0] {
        REG_DAMPING_K    = 3'd0,
        REG_LOW_EDGE_A1  = 3'd1,
        REG_LOW_EDGE_A2  = 3'd2,
        REG_LOW_EDGE_A3  = 3'd3,
        REG_HIGH_EDGE_A1 = 3'd4,
        REG_HIGH_EDGE_A2 = 3'd5,
        REG_HIGH_EDGE_A3 = 3'd6,
        REG_PHASE_WEIGHT = 3'd7
    } reg_index_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_LOAD,    // x from sample, select channel
        OP_V3,      // v3 = x - ic2
        OP_V1,      // v1 = a1*ic1 + a2*v3
        OP_V2,      // v2 = ic2 + a2*ic1 + a3*v3
        OP_IC,      // write both integrators
        OP_HP,      // hp = x - k*v1 - v2, becomes next section input
        OP_Q,       // q = v1l + v1h
        OP_Y,       // y = v2 + sign*w*q
        OP_LIM,     // start soft limit divide
        OP_LIMFIN,  // finish soft limit
        OP_GAIN,    // gain and output rescale
        OP_PUT,     // copy the finished pair to the output register
        OP_NOP
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       chan;     // 0 left, 1 right
        logic       sect;     // 0 low edge, 1 high edge
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_stat_t;

endpackage : sdsvf_pkg
`default_nettype wire

// File: rtl/core/sdsvf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsvf_ctrl
// Sequencer that steps the datapath through both channels of one item.
// ----------------------------------------------------------------------------
module sdsvf_ctrl
    import sdsvf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_fire,
    input  wire logic     out_free,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy,
    output logic          done
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_V3, S_V1, S_V2, S_IC, S_HP, S_Q, S_Y,
        S_LIM, S_WAIT, S_FIN, S_GAIN, S_PUT
    } state_t;

    state_t state_reg, state_next;
    logic   chan_reg, chan_next;
    logic   sect_reg, sect_next;

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        sect_next  = sect_reg;
        cmd.op     = OP_NOP;
        cmd.chan   = chan_reg;
        cmd.sect   = sect_reg;
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_LOAD;
                    chan_next  = 1'b0;
                end
            end
            S_LOAD:
            begin
                cmd.op = OP_LOAD; sect_next = 1'b0; state_next = S_V3;
            end
            S_V3: begin cmd.op = OP_V3; state_next = S_V1; end
            S_V1: begin cmd.op = OP_V1; state_next = S_V2; end
            S_V2: begin cmd.op = OP_V2; state_next = S_IC; end
            S_IC:
            begin
                cmd.op = OP_IC;
                state_next = sect_reg ? S_Q : S_HP;
            end
            S_HP:
            begin
                cmd.op = OP_HP; sect_next = 1'b1; state_next = S_V3;
            end
            S_Q: begin cmd.op = OP_Q; state_next = S_Y; end
            S_Y: begin cmd.op = OP_Y; state_next = S_LIM; end
            S_LIM: begin cmd.op = OP_LIM; state_next = S_WAIT; end
            S_WAIT: if (!stat.div_busy) state_next = S_FIN;
            S_FIN: begin cmd.op = OP_LIMFIN; state_next = S_GAIN; end
            S_GAIN:
            begin
                cmd.op = OP_GAIN;
                if (chan_reg)
                    state_next = S_PUT;
                else
                begin
                    chan_next  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    cmd.op = OP_PUT;
                    done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg  <= 1'b0;
            sect_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            sect_reg  <= sect_next;
        end
    end

endmodule : sdsvf_ctrl
`default_nettype wire

// File: rtl/core/sdsvf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsvf_div
// Restoring divider giving a 30-bit truncated fraction e/den, one bit a cycle.
// ----------------------------------------------------------------------------
module sdsvf_div
    import sdsvf_pkg::*;
#(
    parameter int W = STATE_WIDTH_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [W:0]    num,
    input  wire logic [W:0]    den,
    output logic               busy,
    output logic [29:0]        quot
);

    logic [W+1:0] rem_reg;
    logic [W:0]   den_reg;
    logic [29:0]  quot_reg;
    logic [4:0]   cnt_reg;
    logic [W+1:0] shifted;

    assign shifted = {rem_reg[W:0], 1'b0};
    assign busy    = (cnt_reg != 5'd0);
    assign quot    = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 5'd0;
        else if (start)
            cnt_reg <= 5'd30;
        else if (busy)
            cnt_reg <= cnt_reg - 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_reg  <= shifted - {1'b0, den_reg};
                quot_reg <= {quot_reg[28:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted;
                quot_reg <= {quot_reg[28:0], 1'b0};
            end
        end
    end

endmodule : sdsvf_div
`default_nettype wire

// File: rtl/core/sdsvf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsvf_dp
// Datapath: integrator store, multiply-round steps, limiter, output.
// ----------------------------------------------------------------------------
module sdsvf_dp
    import sdsvf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = STATE_WIDTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dp_cmd_t                      cmd,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]   cfg_idx,
    input  wire logic [COEF_WIDTH-1:0]        cfg_data,
    input  wire logic                         in_fire,
    input  wire logic signed [SAMPLE_WIDTH-1:0] left_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0] right_in,
    input  wire logic [GAIN_WIDTH-1:0]        out_gain,
    output dp_stat_t                          stat,
    output logic signed [SAMPLE_WIDTH:0]      left_out,
    output logic signed [SAMPLE_WIDTH:0]      right_out
);

    localparam int SW   = STATE_WIDTH;
    localparam int SF   = SW - 4;
    localparam int SFR  = SAMPLE_WIDTH - 1;
    localparam int OW   = SAMPLE_WIDTH + 1;
    localparam int PW   = SW + 34;           // wide sum width
    localparam int MW   = (SW > SAMPLE_WIDTH) ? SW : SAMPLE_WIDTH;
    localparam longint SMAX = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SMIN = -SMAX - 1;
    localparam longint OMAX = (64'sd1 <<< (OW - 1)) - 1;
    localparam longint OMIN = -OMAX - 1;
    localparam longint T_S  = (SF >= 30) ? (T_Q30 <<< (SF - 30))
                              : ((T_Q30 + (64'sd1 <<< (29 - SF))) >>> (30 - SF));
    localparam longint D_S  = (SF >= 30) ? (D_Q30 <<< (SF - 30))
                              : ((D_Q30 + (64'sd1 <<< (29 - SF))) >>> (30 - SF));

    typedef logic signed [SW-1:0] st_t;

    // Configuration registers.
    logic [COEF_WIDTH-1:0]          k_reg;
    logic [COEF_WIDTH-1:0]          a_reg [6];
    logic signed [WEIGHT_WIDTH-1:0] w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
            w_reg <= '0;
            for (int i = 0; i < 6; i++)
                a_reg[i] <= (i == 0 || i == 3) ? 32'h4000_0000 : '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_idx))
                REG_DAMPING_K:    k_reg <= cfg_data;
                REG_PHASE_WEIGHT: w_reg <= cfg_data[WEIGHT_WIDTH-1:0];
                default:          a_reg[cfg_idx - 3'd1] <= cfg_data;
            endcase
        end
    end

    // Rounded product of an unsigned multiplier and a signed value. Every
    // operand lies within the state or sample range, so its magnitude fits
    // MW bits and the multiplier stays near 33 by 32 bits.
    function automatic logic signed [PW-1:0] mulr(input logic [32:0] c,
                                                  input logic signed [PW-1:0] s,
                                                  input int sh);
        logic [PW-1:0]   smag;
        logic [MW-1:0]   mag;
        logic [MW+32:0]  p;
        logic [PW-1:0]   r;
        begin
            smag = s[PW-1] ? -s : s;
            mag  = smag[MW-1:0];
            p    = {33'd0, mag} * {{MW{1'b0}}, c};
            p    = p + ((MW + 33)'(1) << (sh - 1));
            r    = PW'(p >> sh);
            mulr = s[PW-1] ? -$signed(r) : $signed(r);
        end
    endfunction

    function automatic st_t sat(input logic signed [PW-1:0] v);
        begin
            if (v > PW'(SMAX))      sat = st_t'(SMAX);
            else if (v < PW'(SMIN)) sat = st_t'(SMIN);
            else                    sat = st_t'(v);
        end
    endfunction

    function automatic logic signed [PW-1:0] ext(input st_t v);
        ext = PW'(v);
    endfunction

    // Integrator store: flip-flops, cleared at reset.
    st_t ic_reg [8];
    st_t x_reg, v3_reg, v1_reg, v2_reg, v1l_reg, v1h_reg, q_reg, y_reg;
    logic signed [SAMPLE_WIDTH-1:0] l_smp_reg, r_smp_reg;
    logic [GAIN_WIDTH-1:0] gain_reg;
    logic signed [OW-1:0]  lo_reg, ro_reg, lout_reg, rout_reg;
    logic [2:0] base;
    logic signed [PW-1:0] xs, hp_w, y_w, lim_w, g_w, o_w, e_w;
    logic [29:0] ratio;
    logic div_busy;

    assign base = {cmd.chan, cmd.sect, 1'b0};

    assign xs = cmd.chan ? PW'(r_smp_reg) : PW'(l_smp_reg);

    always_comb
    begin
        hp_w = ext(x_reg) - mulr({1'b0, k_reg}, ext(v1_reg), 30) - ext(v2_reg);
        y_w  = mulr({17'd0, w_reg[15] ? -w_reg : w_reg}, ext(q_reg), 15);
        if (w_reg[15] ^ cmd.chan)
            y_w = ext(v2_reg) - y_w;
        else
            y_w = ext(v2_reg) + y_w;
        e_w  = (y_reg[SW-1] ? -ext(y_reg) : ext(y_reg)) - PW'(T_S);
        lim_w = PW'(T_S) + mulr({3'd0, ratio}, PW'(D_S), 30);
        if (y_reg[SW-1]) lim_w = -lim_w;
        g_w = ext(sat(mulr({15'd0, gain_reg}, ext(y_reg), 16)));
        if (SF > SFR) o_w = mulr(33'd1, g_w, SF - SFR);
        else          o_w = g_w <<< (SFR - SF);
    end

    sdsvf_div #(.W(SW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_LIM && e_w > 0),
        .num   ((SW + 1)'(e_w)),
        .den   ((SW + 1)'(e_w + PW'(D_S))),
        .busy  (div_busy),
        .quot  (ratio)
    );
    assign stat.div_busy = div_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < 8; i++) ic_reg[i] <= '0;
        else if (cmd.op == OP_IC)
        begin
            ic_reg[base]         <= sat((ext(v1_reg) <<< 1) - ext(ic_reg[base]));
            ic_reg[base + 3'd1]  <= sat((ext(v2_reg) <<< 1) - ext(ic_reg[base + 3'd1]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            l_smp_reg <= left_in;
            r_smp_reg <= right_in;
            gain_reg  <= (out_gain > GAIN_MAX) ? GAIN_MAX : out_gain;
        end
        case (cmd.op)
            OP_LOAD: x_reg <= sat((SF >= SFR) ? (xs <<< (SF - SFR))
                                              : mulr(33'd1, xs, SFR - SF));
            OP_V3:   v3_reg <= sat(ext(x_reg) - ext(ic_reg[base + 3'd1]));
            OP_V1:   v1_reg <= sat(mulr({1'b0, a_reg[{cmd.sect, 2'b00} - 3'd0 + 3'd0 +
                                     (cmd.sect ? 3'd3 : 3'd0) - {cmd.sect, 2'b00}]},
                                     ext(ic_reg[base]), 30)
                               + mulr({1'b0, a_reg[cmd.sect ? 3'd4 : 3'd1]},
                                     ext(v3_reg), 30));
            OP_V2:   v2_reg <= sat(ext(ic_reg[base + 3'd1])
                               + mulr({1'b0, a_reg[cmd.sect ? 3'd4 : 3'd1]},
                                     ext(ic_reg[base]), 30)
                               + mulr({1'b0, a_reg[cmd.sect ? 3'd5 : 3'd2]},
                                     ext(v3_reg), 30));
            OP_IC:
            begin
                if (cmd.sect) v1h_reg <= v1_reg;
                else          v1l_reg <= v1_reg;
            end
            OP_HP:   x_reg <= sat(hp_w);
            OP_Q:    q_reg <= sat(ext(v1l_reg) + ext(v1h_reg));
            OP_Y:    y_reg <= sat(y_w);
            OP_LIMFIN: if (e_w > 0) y_reg <= sat(lim_w);
            OP_GAIN:
            begin
                if (cmd.chan)
                    ro_reg <= (o_w > PW'(OMAX)) ? OW'(OMAX)
                            : (o_w < PW'(OMIN)) ? OW'(OMIN) : OW'(o_w);
                else
                    lo_reg <= (o_w > PW'(OMAX)) ? OW'(OMAX)
                            : (o_w < PW'(OMIN)) ? OW'(OMIN) : OW'(o_w);
            end
            // The output register holds the presented pair while the next
            // item is already being worked on.
            OP_PUT:
            begin
                lout_reg <= lo_reg;
                rout_reg <= ro_reg;
            end
            default: ;
        endcase
    end

    assign left_out  = lout_reg;
    assign right_out = rout_reg;

endmodule : sdsvf_dp
`default_nettype wire

// File: rtl/core/stereo_dual_svf_band_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_dual_svf_band_filter_core
// Stereo bandpass built from two trapezoidal SVF sections per channel.
// ----------------------------------------------------------------------------
// Items are processed one at a time. Each channel runs the two sections, the
// mix and the limiter check, plus a divide when its sample needs soft
// limiting. The finished pair moves to an output register, so the next item
// is accepted while the previous result still waits; it stalls only at its
// own output cycle until that result is taken. Coefficients must be written
// over the configuration port only while idle; the block itself does not
// enforce this.
module stereo_dual_svf_band_filter_core
    import sdsvf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = STATE_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire logic [COEF_WIDTH-1:0]          cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] left_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0] right_in,
    input  wire logic [GAIN_WIDTH-1:0]          out_gain,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [SAMPLE_WIDTH:0]        left_out,
    output logic signed [SAMPLE_WIDTH:0]        right_out
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     busy, done, in_fire, out_valid_reg;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = !busy;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    sdsvf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (!out_valid_reg || out_ready),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    sdsvf_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .STATE_WIDTH(STATE_WIDTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_gain  (out_gain),
        .stat      (stat),
        .left_out  (left_out),
        .right_out (right_out)
    );

endmodule : stereo_dual_svf_band_filter_core
`default_nettype wire
